FILE: hw/rtl/fbglyph_pkg.sv
// Shared constants for the framebuffer glyph draw engine: commands, registers, field layout.
package fbglyph_pkg;

  // Command codes carried in s_tuser
  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_FILL   = 3'd2;
  localparam logic [2:0] OP_GLYPH  = 3'd3;
  localparam logic [2:0] OP_SEARCH = 3'd4;

  // Configuration register indexes
  localparam logic REG_CANVAS_WIDTH  = 1'b0;
  localparam logic REG_CANVAS_HEIGHT = 1'b1;

  localparam int OP_W     = 3;
  localparam int X_W      = 7;
  localparam int Y_W      = 4;
  localparam int COLOUR_W = 24;
  localparam int GW_W     = 4;
  localparam int GBITS_W  = 40;
  localparam int CW_W     = 7;
  localparam int CH_W     = 5;

  // Input tdata layout, lowest bit first
  localparam int X_LSB      = 0;
  localparam int Y_LSB      = X_LSB + X_W;
  localparam int COLOUR_LSB = Y_LSB + Y_W;
  localparam int GW_LSB     = COLOUR_LSB + COLOUR_W;
  localparam int GBITS_LSB  = GW_LSB + GW_W;
  localparam int S_DATA_W   = 80;
  localparam int M_DATA_W   = 32;

  // Rows held in glyph_bits; higher rows read as blank
  localparam int GLYPH_STORED_ROWS = 5;
  localparam int GLYPH_EXT_W       = 64;
  localparam logic [GW_W-1:0] GLYPH_MAX_COLS = 4'd8;

  // Row-major linear index: 4-bit row times 7-bit width plus 7-bit column
  localparam int LIN_W = 12;

endpackage

FILE: hw/rtl/framebuffer_glyph_draw_engine.sv
// Framebuffer with pixel access, fill, colour search and bitmap glyph drawing.
//
//  channel   direction  payload
//  s_*       in         s_tuser: op; s_tdata: x_pos, y_pos, colour, glyph_width, glyph_bits
//  m_*       out        m_tdata: pixel_colour, colour_found, range_error
//  cfg_*     in         cfg_index selects canvas_width (0) or canvas_height (1)
//
// Each request is sequenced through the single port pair of the pixel memory, one access a cycle,
// and its result then loads the output register.
// After reset a clearing pass blacks every pixel of the memory; s_tready stays low meanwhile.
// The output register lets the next request in while a result waits on m_tready.
module framebuffer_glyph_draw_engine #(
  parameter int MAX_PIXELS = 256,
  parameter int GLYPH_ROWS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // x_pos[6:0], y_pos[10:7], colour[34:11],
                                 // glyph_width[38:35], glyph_bits[78:39], zero pad
  input  logic [2:0]  s_tuser,   // op[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_colour[23:0], colour_found[24],
                                 // range_error[25], zero pad
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int ADDR_W = $clog2(MAX_PIXELS);
  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int GROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_PIXEL  = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_GLYPH  = 3'd5;
  localparam logic [2:0] ST_SEARCH = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0] state;

  logic [fbglyph_pkg::CW_W-1:0] canvas_width;
  logic [fbglyph_pkg::CH_W-1:0] canvas_height;

  // Latched request
  logic [fbglyph_pkg::OP_W-1:0]     cmd_op;
  logic [fbglyph_pkg::X_W-1:0]      cmd_x;
  logic [fbglyph_pkg::Y_W-1:0]      cmd_y;
  logic [fbglyph_pkg::COLOUR_W-1:0] cmd_colour;
  logic [fbglyph_pkg::GW_W-1:0]     cmd_gw;
  logic [fbglyph_pkg::GBITS_W-1:0]  cmd_bits;

  logic [fbglyph_pkg::COLOUR_W-1:0] res_colour;
  logic                             res_found;
  logic                             res_rerr;

  logic [CNT_W-1:0]  cnt;
  logic              search_pend;
  logic [2:0]        col_cnt;
  logic [GROW_W-1:0] row_cnt;

  // Pixel memory
  logic [fbglyph_pkg::COLOUR_W-1:0] mem [MAX_PIXELS];
  logic                             wr_en;
  logic [ADDR_W-1:0]                wr_addr;
  logic [fbglyph_pkg::COLOUR_W-1:0] wr_data;
  logic                             rd_en;
  logic [ADDR_W-1:0]                rd_addr;
  logic [fbglyph_pkg::COLOUR_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Pixels covered by fill and search
  logic [fbglyph_pkg::LIN_W-1:0] wh_prod;
  logic [CNT_W-1:0]              n_use;

  assign wh_prod = fbglyph_pkg::LIN_W'(canvas_width) * fbglyph_pkg::LIN_W'(canvas_height);
  assign n_use   = (32'(wh_prod) < MAX_PIXELS) ? CNT_W'(wh_prod) : CNT_W'(MAX_PIXELS);

  // Shared bounds check and index for pixel and glyph cells
  logic [7:0]                    loc_x;
  logic [fbglyph_pkg::Y_W-1:0]   loc_y;
  logic [fbglyph_pkg::LIN_W-1:0] lin;
  logic                          loc_ok;

  assign loc_x = (state == ST_GLYPH) ? ({cmd_x[6], cmd_x} + {5'b0, col_cnt})
                                     : {cmd_x[6], cmd_x};
  assign loc_y = (state == ST_GLYPH) ? fbglyph_pkg::Y_W'(row_cnt) : cmd_y;
  assign lin   = fbglyph_pkg::LIN_W'(loc_y) * fbglyph_pkg::LIN_W'(canvas_width)
               + fbglyph_pkg::LIN_W'(loc_x[6:0]);
  assign loc_ok = !loc_x[7] && (loc_x[6:0] < canvas_width)
               && ({1'b0, loc_y} < canvas_height) && (32'(lin) < MAX_PIXELS);

  // Glyph cell lookup; columns run from bit glyph_width-1 down to bit 0 within each row byte
  logic [fbglyph_pkg::GW_W-1:0]        gw_clamp;
  logic [2:0]                          bit_idx;
  logic [fbglyph_pkg::GLYPH_EXT_W-1:0] glyph_ext;
  logic [7:0]                          row_byte;
  logic                                cell_set;
  logic                                last_row;
  logic                                last_col;

  assign gw_clamp  = (cmd_gw > fbglyph_pkg::GLYPH_MAX_COLS) ? fbglyph_pkg::GLYPH_MAX_COLS
                                                            : cmd_gw;
  assign bit_idx   = 3'(gw_clamp - 4'd1 - {1'b0, col_cnt});
  assign glyph_ext = {{(fbglyph_pkg::GLYPH_EXT_W - fbglyph_pkg::GBITS_W){1'b0}}, cmd_bits};
  assign row_byte  = glyph_ext[{3'(row_cnt), 3'b000} +: 8];
  assign cell_set  = row_byte[bit_idx];
  assign last_row  = (row_cnt == GROW_W'(GLYPH_ROWS - 1));
  assign last_col  = ({1'b0, col_cnt} == (gw_clamp - 4'd1));

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt[ADDR_W-1:0];
    wr_data = cmd_colour;
    rd_en   = 1'b0;
    rd_addr = cnt[ADDR_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      ST_PIXEL: begin
        if (loc_ok) begin
          if (cmd_op == fbglyph_pkg::OP_WRITE) begin
            wr_en   = 1'b1;
            wr_addr = lin[ADDR_W-1:0];
          end else begin
            rd_en   = 1'b1;
            rd_addr = lin[ADDR_W-1:0];
          end
        end
      end
      ST_FILL: begin
        wr_en = (cnt < n_use);
      end
      ST_GLYPH: begin
        if ((gw_clamp != '0) && cell_set && loc_ok) begin
          wr_en   = 1'b1;
          wr_addr = lin[ADDR_W-1:0];
        end
      end
      ST_SEARCH: begin
        rd_en = (cnt < n_use);
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= 7'd16;
      canvas_height <= 5'd5;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fbglyph_pkg::REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        fbglyph_pkg::REG_CANVAS_HEIGHT: canvas_height <= cfg_data[fbglyph_pkg::CH_W-1:0];
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cnt         <= '0;
      search_pend <= 1'b0;
      col_cnt     <= '0;
      row_cnt     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_op      <= s_tuser;
            cmd_x       <= s_tdata[fbglyph_pkg::X_LSB +: fbglyph_pkg::X_W];
            cmd_y       <= s_tdata[fbglyph_pkg::Y_LSB +: fbglyph_pkg::Y_W];
            cmd_colour  <= s_tdata[fbglyph_pkg::COLOUR_LSB +: fbglyph_pkg::COLOUR_W];
            cmd_gw      <= s_tdata[fbglyph_pkg::GW_LSB +: fbglyph_pkg::GW_W];
            cmd_bits    <= s_tdata[fbglyph_pkg::GBITS_LSB +: fbglyph_pkg::GBITS_W];
            res_colour  <= '0;
            res_found   <= 1'b0;
            res_rerr    <= 1'b0;
            cnt         <= '0;
            search_pend <= 1'b0;
            col_cnt     <= '0;
            row_cnt     <= '0;
            unique case (s_tuser)
              fbglyph_pkg::OP_WRITE,
              fbglyph_pkg::OP_READ:   state <= ST_PIXEL;
              fbglyph_pkg::OP_FILL:   state <= ST_FILL;
              fbglyph_pkg::OP_GLYPH:  state <= ST_GLYPH;
              fbglyph_pkg::OP_SEARCH: state <= ST_SEARCH;
              default:                state <= ST_DONE;
            endcase
          end
        end
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(MAX_PIXELS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_PIXEL: begin
          if (!loc_ok) begin
            res_rerr <= 1'b1;
            state    <= ST_DONE;
          end else if (cmd_op == fbglyph_pkg::OP_WRITE) begin
            state <= ST_DONE;
          end else begin
            state <= ST_RDWAIT;
          end
        end
        ST_RDWAIT: begin
          res_colour <= rd_data;
          state      <= ST_DONE;
        end
        ST_FILL: begin
          if (cnt < n_use) begin
            cnt <= cnt + 1'b1;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_GLYPH: begin
          if (gw_clamp == '0) begin
            state <= ST_DONE;
          end else if (last_row) begin
            row_cnt <= '0;
            if (last_col) begin
              state <= ST_DONE;
            end else begin
              col_cnt <= col_cnt + 3'd1;
            end
          end else begin
            row_cnt <= row_cnt + 1'b1;
          end
        end
        ST_SEARCH: begin
          // reads issue one a cycle; data is compared the cycle after
          if (search_pend && (rd_data == cmd_colour)) begin
            res_found <= 1'b1;
          end
          if (cnt < n_use) begin
            cnt         <= cnt + 1'b1;
            search_pend <= 1'b1;
          end else begin
            search_pend <= 1'b0;
            if (!search_pend) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_tdata <= {6'b0, res_rerr, res_found, res_colour};
    end
  end

endmodule

FILE: bench/tb.sv
// Self-checking bench for the framebuffer glyph draw engine: directed and random commands against a canvas model.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_PIX     = 256;
  localparam int QUIET_LIMIT = 4000;  // clearing pass, long hold-off and full fills fit well inside
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;   // longer than a full-canvas search
  localparam int RANDOM_PER_PHASE = 120;
  localparam int NUM_PHASES  = 10;

  localparam int PHASE_WIDTHS  [NUM_PHASES] = '{16, 1, 64, 0, 8, 127, 7, 64, 33, 20};
  localparam int PHASE_HEIGHTS [NUM_PHASES] = '{5, 1, 16, 5, 0, 31, 3, 4, 9, 13};

  // op codes the block leaves unused
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct {
    logic [23:0] pixel_colour;
    logic        colour_found;
    logic        range_error;
  } readout_t;

  class canvas_tracker;
    logic [23:0] pixels [MAX_PIX];
    int          width;
    int          height;
    readout_t    owed_readouts[$];
    int          faults;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      width  = 16;
      height = 5;
      faults = 0;
    endfunction

    function void set_reg(logic idx, logic [6:0] value);
      if (idx == fbglyph_pkg::REG_CANVAS_WIDTH) width = value;
      else height = value[4:0];
    endfunction

    function int span();
      int n;
      n = width * height;
      return (n < MAX_PIX) ? n : MAX_PIX;
    endfunction

    function bit locate(int x, int y, output int idx);
      idx = 0;
      if (x < 0 || x >= width || y >= height) return 0;
      idx = y * width + x;
      return idx < MAX_PIX;
    endfunction

    // Applies one accepted command to the canvas and queues the reply it owes.
    function void note_request(logic [2:0] op, logic signed [6:0] x, logic [3:0] y,
                               logic [23:0] colour, logic [3:0] gw, logic [39:0] gbits);
      readout_t rd;
      int xi, idx, cols, bitpos;
      logic [7:0] row;
      rd = '{default: '0};
      xi = x;
      case (op)
        fbglyph_pkg::OP_WRITE: begin
          if (locate(xi, y, idx)) pixels[idx] = colour;
          else rd.range_error = 1'b1;
        end
        fbglyph_pkg::OP_READ: begin
          if (locate(xi, y, idx)) rd.pixel_colour = pixels[idx];
          else rd.range_error = 1'b1;
        end
        fbglyph_pkg::OP_FILL: begin
          for (int i = 0; i < span(); i++) pixels[i] = colour;
        end
        fbglyph_pkg::OP_GLYPH: begin
          cols = (gw > fbglyph_pkg::GLYPH_MAX_COLS) ? fbglyph_pkg::GLYPH_MAX_COLS : gw;
          for (int c = 0; c < cols; c++) begin
            bitpos = cols - 1 - c;
            for (int r = 0; r < fbglyph_pkg::GLYPH_STORED_ROWS; r++) begin
              row = gbits[8*r +: 8];
              if (row[bitpos] && locate(xi + c, r, idx)) pixels[idx] = colour;
            end
          end
        end
        fbglyph_pkg::OP_SEARCH: begin
          for (int i = 0; i < span(); i++)
            if (pixels[i] == colour) rd.colour_found = 1'b1;
        end
        default: ;
      endcase
      owed_readouts.push_back(rd);
    endfunction

    function void check_reply(logic [31:0] data);
      readout_t want;
      if (owed_readouts.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected reply %h", data);
        return;
      end
      want = owed_readouts.pop_front();
      if (data[23:0] !== want.pixel_colour || data[24] !== want.colour_found ||
          data[25] !== want.range_error) begin
        faults++;
        if (faults <= 10)
          $display("reply mismatch: colour %h/%h found %b/%b range %b/%b (exp/got)",
                   want.pixel_colour, data[23:0], want.colour_found, data[24],
                   want.range_error, data[25]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [6:0]  cfg_data;

  canvas_tracker board = new();
  int  sent_count  = 0;
  int  quiet_cycles = 0;
  bit  calm = 0;  // no idling on either side while set
  logic [23:0] palette [6] = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'h123456,
                               24'h800001, 24'hABCDEF};

  framebuffer_glyph_draw_engine dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic send_request(logic [2:0] op, logic [6:0] x, logic [3:0] y,
                              logic [23:0] colour, logic [3:0] gw, logic [39:0] gbits);
    logic [79:0] word;
    word = '0;
    word[fbglyph_pkg::X_LSB +: fbglyph_pkg::X_W]           = x;
    word[fbglyph_pkg::Y_LSB +: fbglyph_pkg::Y_W]           = y;
    word[fbglyph_pkg::COLOUR_LSB +: fbglyph_pkg::COLOUR_W] = colour;
    word[fbglyph_pkg::GW_LSB +: fbglyph_pkg::GW_W]         = gw;
    word[fbglyph_pkg::GBITS_LSB +: fbglyph_pkg::GBITS_W]   = gbits;
    if (!calm)
      while ($urandom_range(99) < 22) begin
        s_tvalid = 1'b0;
        @(negedge clk);
      end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = word;
    do @(posedge clk); while (!s_tready);
    board.note_request(op, x, y, colour, gw, gbits);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain_replies();
    s_tvalid = 1'b0;
    while (board.owed_readouts.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    board.set_reg(idx, value);
  endtask

  function automatic logic [23:0] pick_colour();
    return ($urandom_range(1) == 0) ? palette[$urandom_range(5)] : 24'($urandom);
  endfunction

  task automatic random_request();
    int pick, xi, top;
    logic [2:0]  op;
    logic [6:0]  x;
    logic [3:0]  y;
    logic [3:0]  gw;
    pick = $urandom_range(99);
    if (pick < 35) op = fbglyph_pkg::OP_WRITE;
    else if (pick < 60) op = fbglyph_pkg::OP_READ;
    else if (pick < 80) op = fbglyph_pkg::OP_GLYPH;
    else if (pick < 88) op = fbglyph_pkg::OP_SEARCH;
    else if (pick < 94) op = fbglyph_pkg::OP_FILL;
    else begin
      case ($urandom_range(2))
        0: op = OP_RSVD5;
        1: op = OP_RSVD6;
        default: op = OP_RSVD7;
      endcase
    end
    if ($urandom_range(99) < 70) begin
      xi = (op == fbglyph_pkg::OP_GLYPH) ? $urandom_range(0, board.width + 8) - 8
                                         : $urandom_range(0, board.width + 1) - 1;
      x = xi[6:0];
    end else begin
      x = 7'($urandom);
    end
    top = (board.height > 15) ? 15 : board.height;
    y = ($urandom_range(99) < 75) ? 4'($urandom_range(0, top)) : 4'($urandom);
    gw = ($urandom_range(99) < 80) ? 4'($urandom_range(0, 8)) : 4'($urandom);
    send_request(op, x, y, pick_colour(), gw, {8'($urandom), 32'($urandom)});
  endtask

  // reply side: random stalls plus one long hold-off while requests keep coming
  initial begin
    bit held;
    held = 0;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && sent_count >= 80) begin
        held = 1;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready = calm ? 1'b1 : ($urandom_range(99) >= 22);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_reply(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = fbglyph_pkg::OP_WRITE;
    cfg_wr_en = 1'b0;
    cfg_index = fbglyph_pkg::REG_CANVAS_WIDTH;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed pass on the reset canvas (16 x 5)
    send_request(fbglyph_pkg::OP_WRITE,  7'd0,  4'd0,  24'hFFFFFF, 4'd0, 40'h0);
    send_request(fbglyph_pkg::OP_WRITE,  7'd15, 4'd4,  24'h000001, 4'hF, 40'hFF_FFFF_FFFF);
    send_request(fbglyph_pkg::OP_READ,   7'd0,  4'd0,  24'h0,      4'd0, 40'h0);
    send_request(fbglyph_pkg::OP_READ,   7'd15, 4'd4,  24'hFFFFFF, 4'd0, 40'h0);
    send_request(fbglyph_pkg::OP_WRITE,  7'h7F, 4'd0,  24'h111111, 4'd0, 40'h0);  // x = -1
    send_request(fbglyph_pkg::OP_WRITE,  7'h40, 4'd1,  24'h222222, 4'd0, 40'h0);  // x = -64
    send_request(fbglyph_pkg::OP_WRITE,  7'd16, 4'd0,  24'h333333, 4'd0, 40'h0);  // past width
    send_request(fbglyph_pkg::OP_READ,   7'd63, 4'd15, 24'h0,      4'd0, 40'h0);
    send_request(fbglyph_pkg::OP_WRITE,  7'd3,  4'd5,  24'h444444, 4'd0, 40'h0);  // past height
    send_request(fbglyph_pkg::OP_READ,   7'd3,  4'd15, 24'h0,      4'd0, 40'h0);
    send_request(fbglyph_pkg::OP_SEARCH, 7'd0,  4'd0,  24'hFFFFFF, 4'd0, 40'h0);
    send_request(fbglyph_pkg::OP_SEARCH, 7'd0,  4'd0,  24'h123456, 4'd0, 40'h0);
    // glyph hanging off the left edge, then off the right edge
    send_request(fbglyph_pkg::OP_GLYPH,  7'h7D, 4'd0,  24'h00FF00, 4'd8, 40'hFF_FFFF_FFFF);
    send_request(fbglyph_pkg::OP_GLYPH,  7'd12, 4'd0,  24'h0000FF, 4'd8, 40'hA5_5A_C3_3C_81);
    send_request(fbglyph_pkg::OP_GLYPH,  7'd4,  4'd0,  24'hFF0000, 4'd0, 40'hFF_FFFF_FFFF);
    send_request(fbglyph_pkg::OP_GLYPH,  7'd0,  4'd2,  24'h800001, 4'hF, 40'h01_80_F0_0F_55);
    send_request(fbglyph_pkg::OP_READ,   7'd2,  4'd2,  24'h0,      4'd0, 40'h0);
    send_request(fbglyph_pkg::OP_READ,   7'd13, 4'd0,  24'h0,      4'd0, 40'h0);
    send_request(OP_RSVD5,               7'h7F, 4'hF,  24'hFFFFFF, 4'hF, 40'hFF_FFFF_FFFF);
    send_request(OP_RSVD6,               7'd0,  4'd0,  24'h0,      4'd0, 40'h0);
    send_request(OP_RSVD7,               7'd5,  4'd3,  24'h5A5A5A, 4'd3, 40'h12_3456_789A);
    send_request(fbglyph_pkg::OP_FILL,   7'd0,  4'd0,  24'hABCDEF, 4'd0, 40'h0);
    send_request(fbglyph_pkg::OP_SEARCH, 7'd0,  4'd0,  24'hABCDEF, 4'd0, 40'h0);
    send_request(fbglyph_pkg::OP_SEARCH, 7'd0,  4'd0,  24'h000000, 4'd0, 40'h0);
    send_request(fbglyph_pkg::OP_READ,   7'd7,  4'd3,  24'h0,      4'd0, 40'h0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain_replies();
        write_reg(fbglyph_pkg::REG_CANVAS_WIDTH,  7'(PHASE_WIDTHS[p]));
        write_reg(fbglyph_pkg::REG_CANVAS_HEIGHT, 7'(PHASE_HEIGHTS[p]));
      end
      calm = (p == 2);
      repeat (RANDOM_PER_PHASE) random_request();
    end
    drain_replies();
    calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.faults == 0 && board.owed_readouts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fbglyph_pkg.sv
hw/rtl/framebuffer_glyph_draw_engine.sv
bench/tb.sv
